// ===== hw/rtl/erot_pkg.sv =====
// erot_pkg: shared constants, tables and helpers for the euler point rotator
// no dependencies
package erot_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_W     = 34;
	localparam int COEF_W       = 17;
	localparam int GAIN_INV     = 652032874;
	localparam int UNIT         = 32768;
	localparam int ROUND_HALF   = 16384;
	localparam int FRAC_SHIFT   = 15;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	// round q3.30 to q1.15 and clamp to plus or minus one
	function automatic logic signed [COEF_W-1:0] to_unit(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W-1:0] t;
		logic signed [COEF_W-1:0] r;
		t = (v + CORDIC_W'(ROUND_HALF)) >>> FRAC_SHIFT;
		if (t > CORDIC_W'(UNIT)) begin
			r = COEF_W'(UNIT);
		end else if (t < -CORDIC_W'(UNIT)) begin
			r = -COEF_W'(UNIT);
		end else begin
			r = t[COEF_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/erot_if.sv =====
// erot_if: point and result stream interfaces
// depends on erot_pkg for default widths
interface erot_in_if #(
	parameter int COORD_WIDTH = erot_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = erot_pkg::ANGLE_WIDTH
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic signed [ANGLE_WIDTH-1:0] angle_x;
	logic signed [ANGLE_WIDTH-1:0] angle_y;
	logic signed [ANGLE_WIDTH-1:0] angle_z;

	modport source (output valid, point_x, point_y, point_z, angle_x, angle_y, angle_z,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, angle_x, angle_y, angle_z,
		output ready);
endinterface

interface erot_out_if #(
	parameter int COORD_WIDTH = erot_pkg::COORD_WIDTH
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] rotated_x;
	logic signed [COORD_WIDTH-1:0] rotated_y;
	logic signed [COORD_WIDTH-1:0] rotated_z;

	modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
	modport sink (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

// ===== hw/rtl/erot_front.sv =====
// erot_front: input register, packs point and angles and flags zero residues
// depends on erot_pkg and erot_in_if
module erot_front #(
	parameter int COORD_WIDTH = erot_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = erot_pkg::ANGLE_WIDTH,
	parameter int WORD_W      = 3 * COORD_WIDTH + 3 * (ANGLE_WIDTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	erot_in_if.sink           src,
	output logic              push_valid,
	input  logic              push_ready,
	output logic [WORD_W-1:0] push_word
);
	import erot_pkg::*;

	localparam int AW1 = ANGLE_WIDTH + 1;

	logic              valid_q;
	logic [WORD_W-1:0] word_q;
	logic [ANGLE_WIDTH-1:0] ang [3];
	logic [AW1-1:0] tag [3];

	assign ang[0] = src.angle_x;
	assign ang[1] = src.angle_y;
	assign ang[2] = src.angle_z;

	for (genvar a = 0; a < 3; a++) begin : g_tag
		// quarter turn residue zero gives an exact result
		assign tag[a] = {(ang[a][ANGLE_WIDTH-3:0] == '0), ang[a]};
	end

	assign src.ready  = !valid_q || push_ready;
	assign push_valid = valid_q;
	assign push_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (src.ready) begin
			valid_q <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) begin
			word_q <= {tag[2], tag[1], tag[0], src.point_z, src.point_y, src.point_x};
		end
	end

endmodule

// ===== hw/rtl/erot_queue.sv =====
// erot_queue: short word queue between front and back
// depends on erot_pkg for the depth
module erot_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = erot_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_word,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_word
);
	import erot_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_word   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

endmodule

// ===== hw/rtl/erot_back.sv =====
// erot_back: cordic sine and cosine lanes and three axis rotations
// depends on erot_pkg and erot_out_if
module erot_back #(
	parameter int COORD_WIDTH = erot_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = erot_pkg::ANGLE_WIDTH,
	parameter int WORD_W      = 3 * COORD_WIDTH + 3 * (ANGLE_WIDTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  logic [WORD_W-1:0] pop_word,
	erot_out_if.source        dst
);
	import erot_pkg::*;

	localparam int NS   = CORDIC_STEPS;
	localparam int LAST = NS + 7;
	localparam int AW1  = ANGLE_WIDTH + 1;
	localparam int PRW  = COORD_WIDTH + COEF_W;
	localparam int SW   = PRW + 1;
	localparam int ZSH  = 32 - ANGLE_WIDTH;
	localparam logic signed [SW-1:0] MAXV = {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

	logic en;
	logic [LAST:1] v_s;

	logic signed [CORDIC_W-1:0] cx_s [3][1:NS];
	logic signed [CORDIC_W-1:0] cy_s [3][1:NS];
	logic signed [CORDIC_W-1:0] cz_s [3][1:NS];
	logic [1:0] qd_s [3][1:NS];
	logic       zr_s [3][1:NS];
	logic signed [COORD_WIDTH-1:0] pt_s [1:NS][3];

	logic signed [COORD_WIDTH-1:0] rp_s [4][3];
	logic signed [COEF_W-1:0] cc_s [3][3];
	logic signed [COEF_W-1:0] sc_s [3][3];
	logic signed [COEF_W-1:0] cm_s [3][3];
	logic signed [COEF_W-1:0] sm_s [3][3];
	logic signed [PRW-1:0] ca_s [3];
	logic signed [PRW-1:0] sb_s [3];
	logic signed [PRW-1:0] cb_s [3];
	logic signed [PRW-1:0] sa_s [3];
	logic signed [COORD_WIDTH-1:0] ps_s [3];

	assign en        = !v_s[LAST] || dst.ready;
	assign pop_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[LAST-1:1], pop_valid};
		end
	end

	// cordic lanes, one micro-rotation per stage
	for (genvar a = 0; a < 3; a++) begin : g_lane
		logic [AW1-1:0] tag;
		assign tag = pop_word[3*COORD_WIDTH + a*AW1 +: AW1];

		for (genvar i = 0; i < NS; i++) begin : g_step
			logic signed [CORDIC_W-1:0] xi, yi, zi, at;
			logic [1:0] qi;
			logic zri;
			if (i == 0) begin : g_first
				assign xi  = CORDIC_W'(GAIN_INV);
				assign yi  = '0;
				assign zi  = $signed(CORDIC_W'({tag[ANGLE_WIDTH-3:0], {ZSH{1'b0}}}));
				assign qi  = tag[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
				assign zri = tag[ANGLE_WIDTH];
			end else begin : g_rest
				assign xi  = cx_s[a][i];
				assign yi  = cy_s[a][i];
				assign zi  = cz_s[a][i];
				assign qi  = qd_s[a][i];
				assign zri = zr_s[a][i];
			end
			assign at = $signed(CORDIC_W'(ATAN_TURN[i]));

			always_ff @(posedge clk) begin
				if (en) begin
					if (zi >= 0) begin
						cx_s[a][i+1] <= xi - (yi >>> i);
						cy_s[a][i+1] <= yi + (xi >>> i);
						cz_s[a][i+1] <= zi - at;
					end else begin
						cx_s[a][i+1] <= xi + (yi >>> i);
						cy_s[a][i+1] <= yi - (xi >>> i);
						cz_s[a][i+1] <= zi + at;
					end
					qd_s[a][i+1] <= qi;
					zr_s[a][i+1] <= zri;
				end
			end
		end

		// round, clamp, zero residue override, quadrant fold
		logic signed [COEF_W-1:0] cu, su, cq, sq;
		always_comb begin
			cu = to_unit(cx_s[a][NS]);
			su = to_unit(cy_s[a][NS]);
			if (zr_s[a][NS]) begin
				cu = COEF_W'(UNIT);
				su = '0;
			end
			case (qd_s[a][NS])
				QUAD_0: begin
					cq = cu;
					sq = su;
				end
				QUAD_1: begin
					cq = -su;
					sq = cu;
				end
				QUAD_2: begin
					cq = -cu;
					sq = -su;
				end
				default: begin
					cq = su;
					sq = -cu;
				end
			endcase
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cc_s[0][a] <= cq;
				sc_s[0][a] <= sq;
			end
		end
	end

	// point rides alongside the cordic lanes
	for (genvar i = 0; i < NS; i++) begin : g_pt
		for (genvar k = 0; k < 3; k++) begin : g_c
			always_ff @(posedge clk) begin
				if (en) begin
					if (i == 0) begin
						pt_s[i+1][k] <= pop_word[k*COORD_WIDTH +: COORD_WIDTH];
					end else begin
						pt_s[i+1][k] <= pt_s[i][k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rp_s[0] <= pt_s[NS];
		end
	end

	// rotations about x (y,z), y (x,z), z (x,y)
	for (genvar r = 0; r < 3; r++) begin : g_rot
		localparam int IA = (r == 0) ? 1 : 0;
		localparam int IB = (r == 2) ? 1 : 2;
		localparam int IP = 3 - IA - IB;

		logic signed [SW-1:0] na, nb, ra, rb;
		logic signed [COORD_WIDTH-1:0] oa, ob;

		always_ff @(posedge clk) begin
			if (en) begin
				ca_s[r] <= cc_s[r][r] * rp_s[r][IA];
				sb_s[r] <= sc_s[r][r] * rp_s[r][IB];
				cb_s[r] <= cc_s[r][r] * rp_s[r][IB];
				sa_s[r] <= sc_s[r][r] * rp_s[r][IA];
				ps_s[r] <= rp_s[r][IP];
				cm_s[r] <= cc_s[r];
				sm_s[r] <= sc_s[r];
			end
		end

		always_comb begin
			na = SW'(ca_s[r]) + SW'(sb_s[r]);
			nb = SW'(cb_s[r]) - SW'(sa_s[r]);
			ra = (na + SW'(ROUND_HALF)) >>> FRAC_SHIFT;
			rb = (nb + SW'(ROUND_HALF)) >>> FRAC_SHIFT;
			oa = (ra > MAXV) ? MAXV[COORD_WIDTH-1:0] :
				(ra < MINV) ? MINV[COORD_WIDTH-1:0] : ra[COORD_WIDTH-1:0];
			ob = (rb > MAXV) ? MAXV[COORD_WIDTH-1:0] :
				(rb < MINV) ? MINV[COORD_WIDTH-1:0] : rb[COORD_WIDTH-1:0];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rp_s[r+1][IA] <= oa;
				rp_s[r+1][IB] <= ob;
				rp_s[r+1][IP] <= ps_s[r];
			end
		end

		if (r < 2) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					cc_s[r+1] <= cm_s[r];
					sc_s[r+1] <= sm_s[r];
				end
			end
		end
	end

	assign dst.valid     = v_s[LAST];
	assign dst.rotated_x = rp_s[3][0];
	assign dst.rotated_y = rp_s[3][1];
	assign dst.rotated_z = rp_s[3][2];

endmodule

// ===== hw/rtl/euler_xyz_point_rotator_unit.sv =====
// euler_xyz_point_rotator_unit: top level, front register, queue, rotation pipeline
// depends on erot_pkg, erot_if, erot_front, erot_queue, erot_back
//
// channel   dir  handshake     word
// pt_in     in   valid/ready   point_x/y/z q16.16, angle_x/y/z binary angle
// pt_out    out  valid/ready   rotated_x/y/z q16.16, saturated
//
// one word per cycle sustained while the output is ready; stages in order: front register, queue,
// 24 cordic stages, one sine/cosine stage, two stages per axis rotation
// reset clears valid flags, queue pointers and queue count only, no clearing pass
// an output stall freezes the rotation pipeline; the queue lets the front keep taking words until it is full
module euler_xyz_point_rotator_unit #(
	parameter int COORD_WIDTH = erot_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = erot_pkg::ANGLE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	erot_in_if.sink    pt_in,
	erot_out_if.source pt_out
);
	import erot_pkg::*;

	localparam int WORD_W = 3 * COORD_WIDTH + 3 * (ANGLE_WIDTH + 1);

	logic              f_valid, f_ready, b_valid, b_ready;
	logic [WORD_W-1:0] f_word, b_word;

	erot_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.ANGLE_WIDTH(ANGLE_WIDTH),
		.WORD_W     (WORD_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src       (pt_in),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_word (f_word)
	);

	erot_queue #(
		.WIDTH(WORD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_word (f_word),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_word  (b_word)
	);

	erot_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.ANGLE_WIDTH(ANGLE_WIDTH),
		.WORD_W     (WORD_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_word (b_word),
		.dst      (pt_out)
	);

endmodule

// ===== hw/rtl/erot_checker.sv =====
// erot_checker: port level checks on the rotator, bound to the top level
// depends on erot_pkg and euler_xyz_point_rotator_unit
module erot_checker #(
	parameter int COORD_WIDTH = erot_pkg::COORD_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [3*COORD_WIDTH-1:0] out_word
);
	import erot_pkg::*;

	logic [6:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 7'(in_valid && in_ready) - 7'(out_valid && out_ready);
		end
	end

	// no result without a word in flight
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == '0) |-> !out_valid) else $error("result with nothing in flight");

	// empty block always takes a word
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == '0) |-> in_ready) else $error("idle block not ready");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_word)) else $error("result changed");

endmodule

bind euler_xyz_point_rotator_unit erot_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_erot_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pt_in.valid),
	.in_ready (pt_in.ready),
	.out_valid(pt_out.valid),
	.out_ready(pt_out.ready),
	.out_word ({pt_out.rotated_z, pt_out.rotated_y, pt_out.rotated_x})
);

// ===== tb/tb_euler_xyz_point_rotator_unit.sv =====
// testbench for euler_xyz_point_rotator_unit: directed table then random points and angles
// depends on erot_pkg, erot_if, the rotator rtl; own cordic model predicts rows not marked known
`timescale 1ns / 100ps
module tb_euler_xyz_point_rotator_unit;
	import erot_pkg::*;

	localparam int N_RANDOM = 1830;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
	} coord_t;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] px, py, pz;
		logic signed [ANGLE_WIDTH-1:0] ax, ay, az;
		bit known;
		coord_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	erot_in_if pt_in ();
	erot_out_if pt_out ();

	euler_xyz_point_rotator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.pt_in(pt_in.sink),
		.pt_out(pt_out.source)
	);

	coord_t rotated_q[$];
	int errors;
	int n_in;
	int n_out;
	int idle_cycles;
	bit stim_done;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s word %0d: got %0d expected %0d", what, n_out, got, want);
		errors++;
	endtask

	function automatic longint floor_shift(input longint v, input int n);
		return v >>> n;
	endfunction

	function automatic void unit_sincos(input logic [ANGLE_WIDTH-1:0] ang,
			output longint cs, output longint sn);
		logic [1:0] quad;
		longint res_a, c, s, xc, yc, zc, dx, dy;
		quad = ang[ANGLE_WIDTH-1 -: 2];
		res_a = longint'(ang[ANGLE_WIDTH-3:0]);
		if (res_a == 0) begin
			c = UNIT;
			s = 0;
		end else begin
			xc = GAIN_INV;
			yc = 0;
			zc = res_a <<< (32 - ANGLE_WIDTH);
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = floor_shift(yc, i);
				dy = floor_shift(xc, i);
				if (zc >= 0) begin
					xc -= dx; yc += dy; zc -= longint'(ATAN_TURN[i]);
				end else begin
					xc += dx; yc -= dy; zc += longint'(ATAN_TURN[i]);
				end
			end
			c = floor_shift(xc + ROUND_HALF, FRAC_SHIFT);
			s = floor_shift(yc + ROUND_HALF, FRAC_SHIFT);
			if (c > UNIT) c = UNIT;
			if (c < -UNIT) c = -UNIT;
			if (s > UNIT) s = UNIT;
			if (s < -UNIT) s = -UNIT;
		end
		case (quad)
			QUAD_0: begin cs = c; sn = s; end
			QUAD_1: begin cs = -s; sn = c; end
			QUAD_2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endfunction

	function automatic longint clip_coord(input longint v);
		longint hi;
		hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic void turn_pair(inout longint a, inout longint b,
			input longint c, input longint s);
		longint na, nb;
		na = c * a + s * b;
		nb = c * b - s * a;
		a = clip_coord(floor_shift(na + ROUND_HALF, FRAC_SHIFT));
		b = clip_coord(floor_shift(nb + ROUND_HALF, FRAC_SHIFT));
	endfunction

	function automatic coord_t rotate_point(input stim_row_t r);
		longint x, y, z, c, s;
		coord_t o;
		x = r.px; y = r.py; z = r.pz;
		unit_sincos(r.ax, c, s);
		turn_pair(y, z, c, s);
		unit_sincos(r.ay, c, s);
		turn_pair(x, z, c, s);
		unit_sincos(r.az, c, s);
		turn_pair(x, y, c, s);
		o.x = x[COORD_WIDTH-1:0];
		o.y = y[COORD_WIDTH-1:0];
		o.z = z[COORD_WIDTH-1:0];
		return o;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic logic [COORD_WIDTH-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom) >>> $urandom_range(0, 14);
		endcase
	endfunction

	function automatic logic [ANGLE_WIDTH-1:0] rand_angle();
		if ($urandom_range(0, 7) == 0)
			return {2'($urandom_range(0, 3)), {(ANGLE_WIDTH-2){1'b0}}};
		return ANGLE_WIDTH'($urandom);
	endfunction

	task automatic send_word(input stim_row_t r);
		int g;
		g = gap_len();
		for (int i = 0; i < g; i++) begin
			pt_in.valid <= 1'b0;
			@(negedge clk);
		end
		pt_in.valid <= 1'b1;
		pt_in.point_x <= r.px; pt_in.point_y <= r.py; pt_in.point_z <= r.pz;
		pt_in.angle_x <= r.ax; pt_in.angle_y <= r.ay; pt_in.angle_z <= r.az;
		do @(posedge clk); while (!pt_in.ready);
		rotated_q.push_back(r.known ? r.res : rotate_point(r));
		n_in++;
		@(negedge clk);
	endtask

	function automatic stim_row_t row(input longint px, py, pz, input int ax, ay, az,
			input bit known, input coord_t res);
		stim_row_t r;
		r.px = COORD_WIDTH'(px); r.py = COORD_WIDTH'(py); r.pz = COORD_WIDTH'(pz);
		r.ax = ANGLE_WIDTH'(ax); r.ay = ANGLE_WIDTH'(ay); r.az = ANGLE_WIDTH'(az);
		r.known = known; r.res = res;
		return r;
	endfunction

	stim_row_t table_rows[$];

	initial begin
		stim_row_t r;
		localparam longint MAXC = 64'sh7fffffff;
		localparam longint MINC = -64'sh80000000;
		errors = 0; n_in = 0; n_out = 0; stim_done = 0;
		arst_n = 1'b0;
		pt_in.valid = 1'b0;
		pt_in.point_x = '0; pt_in.point_y = '0; pt_in.point_z = '0;
		pt_in.angle_x = '0; pt_in.angle_y = '0; pt_in.angle_z = '0;
		// zero angles pass the point through, quarter turns are exact
		table_rows.push_back(row(0, 0, 0, 0, 0, 0, 1, '{0, 0, 0}));
		table_rows.push_back(row(65536, -131072, 196608, 0, 0, 0, 1, '{65536, -131072, 196608}));
		table_rows.push_back(row(MAXC, MINC, MAXC, 0, 0, 0, 1, '{MAXC, MINC, MAXC}));
		table_rows.push_back(row(MINC, MAXC, MINC, 0, 0, 0, 1, '{MINC, MAXC, MINC}));
		table_rows.push_back(row(65536, 0, 0, 0, 0, 16384, 1, '{0, -65536, 0}));
		table_rows.push_back(row(65536, 0, 0, 0, 0, -32768, 1, '{-65536, 0, 0}));
		table_rows.push_back(row(0, 65536, 0, 16384, 0, 0, 1, '{0, 0, -65536}));
		table_rows.push_back(row(65536, 0, 0, 0, -16384, 0, 1, '{0, 0, 65536}));
		// negating the most negative value saturates
		table_rows.push_back(row(MINC, MINC, MINC, -32768, 0, 0, 1, '{MINC, MAXC, MAXC}));
		table_rows.push_back(row(MAXC, MAXC, MAXC, 4096, 4096, 4096, 0, '0));
		table_rows.push_back(row(MINC, MAXC, MINC, 8192, -8192, 8192, 0, '0));
		table_rows.push_back(row(MAXC, MAXC, 0, 0, 0, 8192, 0, '0));
		table_rows.push_back(row(12345678, -7654321, 1000, 1, -1, 32767, 0, '0));
		table_rows.push_back(row(-1, -1, -1, 16383, 16385, -16383, 0, '0));
		table_rows.push_back(row(65536, 65536, 65536, 5461, 10923, -21845, 0, '0));
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (table_rows[i]) send_word(table_rows[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			r.px = rand_coord(); r.py = rand_coord(); r.pz = rand_coord();
			r.ax = rand_angle(); r.ay = rand_angle(); r.az = rand_angle();
			r.known = 0;
			send_word(r);
		end
		pt_in.valid <= 1'b0;
		stim_done = 1;
	end

	// result side: random stalls, check at each accepted word
	initial begin
		int g;
		pt_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (g > 0) begin
				g--;
				pt_out.ready <= 1'b0;
			end else begin
				g = gap_len();
				pt_out.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		coord_t want;
		if (arst_n && pt_out.valid && pt_out.ready) begin
			if (rotated_q.size() == 0) begin
				$display("unexpected word %0d from the rotator", n_out);
				errors++;
			end else begin
				want = rotated_q.pop_front();
				if (pt_out.rotated_x !== want.x) report("rotated_x", pt_out.rotated_x, want.x);
				if (pt_out.rotated_y !== want.y) report("rotated_y", pt_out.rotated_y, want.y);
				if (pt_out.rotated_z !== want.z) report("rotated_z", pt_out.rotated_z, want.z);
			end
			n_out++;
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((pt_in.valid && pt_in.ready) || (pt_out.valid && pt_out.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress, %0d words still due", rotated_q.size());
				$display("RESULT: ERROR");
				$finish;
			end
			if (stim_done && rotated_q.size() == 0) begin
				repeat (DRAIN_CYCLES) @(posedge clk);
				$display("sent %0d points (directed and random angles, extremes, quarter turns)",
					n_in);
				$display("checked %0d rotated points, %0d mismatches", n_out, errors);
				if (errors == 0)
					$display("RESULT: OK");
				else
					$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule
